>>> sv/dpob_pkg.sv
// ============================================================================
// dpob_pkg
// Shared types, register codes, constants and the sine table generator for
// the decaying partial oscillator bank.
// ============================================================================
`default_nettype none

package dpob_pkg;

    // configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // q1.16 one, used for damping, depth and modulation gain
    localparam int DAMP_W = 17;
    localparam logic [DAMP_W-1:0] DAMP_ONE = 17'h10000;

    // register reset values
    localparam logic [3:0]        ACTIVE_RST      = 4'd4;
    localparam logic [DAMP_W-1:0] HIGH_DAMP_RST   = 17'h10000;
    localparam logic [DAMP_W-1:0] CHORUS_DEPTH_RST = 17'h00000;
    localparam logic [23:0]       CHORUS_STEP_RST = 24'h000000;

    // output saturation bounds
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

    // sine series constants
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // register index codes
    typedef enum logic [1:0] {
        REG_ACTIVE       = 2'd0,
        REG_HIGH_DAMP    = 2'd1,
        REG_CHORUS_DEPTH = 2'd2,
        REG_CHORUS_STEP  = 2'd3
    } reg_idx_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [3:0]        active_partials;
        logic [DAMP_W-1:0] high_damping;
        logic [DAMP_W-1:0] chorus_depth;
        logic [23:0]       chorus_step;
    } cfg_t;

    // one partial's stored state
    typedef struct packed {
        logic [23:0] phase;
        logic [23:0] step;
        logic [15:0] level;
        logic [15:0] decay;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic tick_start;
        logic ch_rd;
        logic ch_mul;
        logic ch_am;
        logic part_rd;
        logic part_sine;
        logic part_mul1;
        logic part_mul2;
        logic part_acc;
        logic fin_mul;
        logic fin_add;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic chorus_on;
        logic no_parts;
        logic last_part;
    } stat_t;

    // round(32767*sin(j*pi/2/quarter)) by truncated taylor series
    function automatic logic [15:0] quarter_sine(longint unsigned j, int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        x  = (j * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return 16'(v);
    endfunction

    // full-wave table entry built from the mirrored quarter wave
    function automatic logic signed [15:0] sine_entry(int unsigned i, int unsigned bits);
        int unsigned quarter;
        int unsigned q;
        int unsigned j;
        logic [15:0] v;
        quarter = 1 << (bits - 2);
        q = i >> (bits - 2);
        j = i & (quarter - 1);
        if ((q & 1) != 0) begin
            v = quarter_sine(64'(quarter - j), bits);
        end else begin
            v = quarter_sine(64'(j), bits);
        end
        if ((q & 2) != 0) begin
            return $signed(16'(-v));
        end
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

>>> sv/decaying_partial_oscillator_bank.sv
// ============================================================================
// decaying_partial_oscillator_bank
// Additive bank of decaying sine partials with chorus amplitude modulation.
// ============================================================================
//
// channel   direction  handshake               payload
// s_        in         s_valid / s_ready        req_type, partial_index,
//                                               phase_step, start_level,
//                                               decay_factor, pitch_mult
// m_        out        m_valid / m_ready        sample_out
// apb       in         psel, penable, pwrite    paddr, pwdata / prdata
//
// a load is taken while idle and the input stays open.
// a tick runs the restoring divider for the damping slope, then the chorus
// gain when chorus depth is nonzero, then each active partial in turn
// through the state memory, sine table and two multipliers, then the
// final scaling.
// the finished sample sits in an output register; the next item is taken
// while it waits, and a tick only stalls at its end if the sample is unread.
// reset is synchronous and active low; no clearing pass, partial state
// reads as zero until loaded.
//
`default_nettype none

module decaying_partial_oscillator_bank #(
    parameter int MAX_PARTIALS    = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpob_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dpob_pkg::DATA_W-1:0] pwdata,
    output logic      [dpob_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // input channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_req_type,
    input  wire logic [2:0]                  s_partial_index,
    input  wire logic [23:0]                 s_phase_step,
    input  wire logic [15:0]                 s_start_level,
    input  wire logic [15:0]                 s_decay_factor,
    input  wire logic [15:0]                 s_pitch_mult,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [23:0]               m_sample_out
);
    import dpob_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // configuration registers
    dpob_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    dpob_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // arithmetic and storage
    dpob_dp #(
        .MAX_PARTIALS    (MAX_PARTIALS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .s_partial_index (s_partial_index),
        .s_phase_step    (s_phase_step),
        .s_start_level   (s_start_level),
        .s_decay_factor  (s_decay_factor),
        .s_pitch_mult    (s_pitch_mult),
        .m_sample_out    (m_sample_out)
    );

endmodule

`default_nettype wire

>>> sv/dpob_regs.sv
// ============================================================================
// dpob_regs
// APB-style configuration register file: four write/read registers.
// ============================================================================
`default_nettype none

module dpob_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpob_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dpob_pkg::DATA_W-1:0] pwdata,
    output logic      [dpob_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output dpob_pkg::cfg_t                   cfg
);
    import dpob_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_partials <= ACTIVE_RST;
            cfg_reg.high_damping    <= HIGH_DAMP_RST;
            cfg_reg.chorus_depth    <= CHORUS_DEPTH_RST;
            cfg_reg.chorus_step     <= CHORUS_STEP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ACTIVE:       cfg_reg.active_partials <= pwdata[3:0];
                REG_HIGH_DAMP:    cfg_reg.high_damping    <= pwdata[DAMP_W-1:0];
                REG_CHORUS_DEPTH: cfg_reg.chorus_depth    <= pwdata[DAMP_W-1:0];
                REG_CHORUS_STEP:  cfg_reg.chorus_step     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_ACTIVE:       prdata = DATA_W'(cfg_reg.active_partials);
            REG_HIGH_DAMP:    prdata = DATA_W'(cfg_reg.high_damping);
            REG_CHORUS_DEPTH: prdata = DATA_W'(cfg_reg.chorus_depth);
            REG_CHORUS_STEP:  prdata = DATA_W'(cfg_reg.chorus_step);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/dpob_div.sv
// ============================================================================
// dpob_div
// Restoring divider, one quotient bit per cycle, for the damping slope.
// ============================================================================
`default_nettype none

module dpob_div #(
    parameter int DIV_W = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [dpob_pkg::DAMP_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]            divisor,
    output logic                             done,
    output logic      [dpob_pkg::DAMP_W-1:0] quotient,
    output logic      [DIV_W-1:0]            remainder
);
    import dpob_pkg::*;

    localparam int STEP_W = $clog2(DAMP_W + 1);

    logic                busy_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DAMP_W-1:0]   quo_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dsor_reg;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                fits;

    // trial subtract of the next dividend bit
    assign trial = {rem_reg, quo_reg[DAMP_W-1]};
    assign diff  = trial - {1'b0, dsor_reg};
    assign fits  = trial >= {1'b0, dsor_reg};

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DAMP_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DAMP_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign done      = !busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> sv/dpob_dp.sv
// ============================================================================
// dpob_dp
// Datapath: partial state memory, sine table, multipliers, damping stepper,
// accumulator, chorus gain, final scaling and saturation.
// ============================================================================
`default_nettype none

module dpob_dp #(
    parameter int MAX_PARTIALS    = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dpob_pkg::cfg_t      cfg,
    input  wire dpob_pkg::cmd_t      cmd,
    output dpob_pkg::stat_t          stat,
    input  wire logic [2:0]          s_partial_index,
    input  wire logic [23:0]         s_phase_step,
    input  wire logic [15:0]         s_start_level,
    input  wire logic [15:0]         s_decay_factor,
    input  wire logic [15:0]         s_pitch_mult,
    output logic signed [23:0]       m_sample_out
);
    import dpob_pkg::*;

    localparam int IDX_W     = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
    localparam int CNT_W     = $clog2(MAX_PARTIALS + 1);
    localparam int ACC_W     = 32 + $clog2(MAX_PARTIALS);
    localparam int HI_W      = ACC_W - 16;
    localparam int TOT_W     = ACC_W + 18;
    localparam int Y_W       = TOT_W - 26;
    localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;

    // sine table, constant folded at elaboration
    logic signed [15:0] sine_rom [SINE_SIZE];
    for (genvar gi = 0; gi < SINE_SIZE; gi++) begin : g_sine
        assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
    end

    // partial state memory with per-entry valid bits
    entry_t                  part_mem [MAX_PARTIALS];
    logic [MAX_PARTIALS-1:0] valid_reg;
    entry_t                  rd_entry_reg;
    logic                    rd_valid_reg;
    entry_t                  cur_entry;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    entry_t                  mem_wdata;

    // load decode
    logic [31:0]             load_idx_wide;
    logic                    load_in_range;
    logic [IDX_W-1:0]        load_addr;

    // configuration views
    logic [DAMP_W-1:0]       hd_sat;
    logic [DAMP_W-1:0]       depth_sat;
    logic [DAMP_W-1:0]       damp_span;
    logic [CNT_W-1:0]        count_sat;
    logic [CNT_W-1:0]        denom_cfg;

    // tick state
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        denom_reg;
    logic [DAMP_W-1:0]       depth_reg;
    logic [15:0]             pitch_reg;
    logic [DAMP_W-1:0]       am_reg;
    logic [23:0]             chorus_phase_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [IDX_W-1:0]        n_addr;
    logic [CNT_W:0]          n_plus;
    logic [DAMP_W-1:0]       q_reg;
    logic [CNT_W-1:0]        r_reg;
    logic [CNT_W:0]          r_sum;
    logic                    div_done;
    logic [DAMP_W-1:0]       div_quo;
    logic [CNT_W-1:0]        div_rem;

    // arithmetic pipeline
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic signed [15:0]      sine_reg;
    logic [39:0]             adv_full;
    logic [39:0]             adv_reg;
    logic [31:0]             lev_dec_full;
    logic [31:0]             lev_dec_reg;
    logic signed [32:0]      prod1_full;
    logic signed [31:0]      prod1_reg;
    logic [DAMP_W-1:0]       damp;
    logic signed [49:0]      prod2_full;
    logic signed [47:0]      prod2_reg;
    logic signed [31:0]      term;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]             ch_u;
    logic [32:0]             ch_prod_reg;
    logic [DAMP_W:0]         am_calc;
    logic [15:0]             acc_lo;
    logic signed [HI_W-1:0]  acc_hi;
    logic [32:0]             plo_reg;
    logic signed [HI_W+17:0] phi_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [Y_W-1:0]          yv;
    logic [Y_W-24:0]         y_top;
    logic                    y_ovf;
    logic signed [23:0]      sample_reg;

    // configuration saturation and damping slope operands
    assign hd_sat    = (cfg.high_damping > DAMP_ONE) ? DAMP_ONE : cfg.high_damping;
    assign depth_sat = (cfg.chorus_depth > DAMP_ONE) ? DAMP_ONE : cfg.chorus_depth;
    assign damp_span = DAMP_ONE - hd_sat;
    assign count_sat = (32'(cfg.active_partials) > 32'(MAX_PARTIALS)) ?
                       CNT_W'(MAX_PARTIALS) : CNT_W'(cfg.active_partials);
    assign denom_cfg = (count_sat > CNT_W'(1)) ? count_sat - 1'b1 : CNT_W'(1);

    dpob_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.tick_start),
        .dividend  (damp_span),
        .divisor   (denom_cfg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // load address decode
    assign load_idx_wide = 32'(s_partial_index);
    assign load_in_range = load_idx_wide < 32'(MAX_PARTIALS);
    assign load_addr     = load_idx_wide[IDX_W-1:0];
    assign n_addr        = n_reg[IDX_W-1:0];

    // entry that was never loaded reads as zero
    assign cur_entry = rd_valid_reg ? rd_entry_reg : '0;

    // memory write port: loads while idle, updates during a tick
    always_comb begin
        mem_we    = (cmd.load && load_in_range) || cmd.part_mul1;
        mem_waddr = cmd.load ? load_addr : n_addr;
        if (cmd.load) begin
            mem_wdata.phase = '0;
            mem_wdata.step  = s_phase_step;
            mem_wdata.level = s_start_level;
            mem_wdata.decay = s_decay_factor;
        end else begin
            mem_wdata.phase = cur_entry.phase + adv_reg[35:12];
            mem_wdata.step  = cur_entry.step;
            mem_wdata.level = lev_dec_reg[31:16];
            mem_wdata.decay = cur_entry.decay;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            part_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.part_rd) begin
            rd_entry_reg <= part_mem[n_addr];
            rd_valid_reg <= valid_reg[n_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.load && load_in_range) begin
            valid_reg[load_addr] <= 1'b1;
        end
    end

    // sine table read port, shared by chorus and partials
    assign rom_addr = cmd.ch_rd ? chorus_phase_reg[23 -: SINE_TABLE_BITS]
                                : cur_entry.phase[23 -: SINE_TABLE_BITS];

    always_ff @(posedge aclk) begin
        if (cmd.ch_rd || cmd.part_sine) begin
            sine_reg <= sine_rom[rom_addr];
        end
    end

    // chorus phase accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chorus_phase_reg <= '0;
        end else if (cmd.ch_am) begin
            chorus_phase_reg <= chorus_phase_reg + cfg.chorus_step;
        end
    end

    // products
    assign adv_full     = cur_entry.step * pitch_reg;
    assign lev_dec_full = cur_entry.level * cur_entry.decay;
    assign prod1_full   = sine_reg * $signed({1'b0, cur_entry.level});
    assign damp         = DAMP_ONE - q_reg;
    assign prod2_full   = prod1_reg * $signed({1'b0, damp});
    assign term         = prod2_reg[47:16];
    assign r_sum        = {1'b0, r_reg} + {1'b0, div_rem};
    assign ch_u         = {~sine_reg[15], sine_reg[14:0]};
    assign am_calc      = {1'b0, DAMP_ONE} - {1'b0, depth_reg}
                        + {1'b0, ch_prod_reg[32:16]};
    assign acc_lo       = acc_reg[15:0];
    assign acc_hi       = acc_reg[ACC_W-1:16];

    // tick sequence registers
    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            count_reg <= count_sat;
            denom_reg <= denom_cfg;
            depth_reg <= depth_sat;
            pitch_reg <= s_pitch_mult;
            am_reg    <= DAMP_ONE;
            acc_reg   <= '0;
            n_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
        end
        if (cmd.ch_mul) begin
            ch_prod_reg <= depth_reg * ch_u;
        end
        if (cmd.ch_am) begin
            am_reg <= am_calc[DAMP_W-1:0];
        end
        if (cmd.part_sine) begin
            adv_reg     <= adv_full;
            lev_dec_reg <= lev_dec_full;
        end
        if (cmd.part_mul1) begin
            prod1_reg <= prod1_full[31:0];
        end
        if (cmd.part_mul2) begin
            prod2_reg <= prod2_full[47:0];
        end
        // accumulate and step the damping quotient by the divided slope
        if (cmd.part_acc) begin
            acc_reg <= acc_reg + ACC_W'(term);
            n_reg   <= n_reg + 1'b1;
            if (r_sum >= {1'b0, denom_reg}) begin
                r_reg <= CNT_W'(r_sum - {1'b0, denom_reg});
                q_reg <= q_reg + div_quo + 1'b1;
            end else begin
                r_reg <= r_sum[CNT_W-1:0];
                q_reg <= q_reg + div_quo;
            end
        end
        // split sum times gain into two narrow products
        if (cmd.fin_mul) begin
            plo_reg <= acc_lo * am_reg;
            phi_reg <= acc_hi * $signed({1'b0, am_reg});
        end
        if (cmd.fin_add) begin
            total_reg <= $signed((TOT_W'(phi_reg) << 16) + TOT_W'(plo_reg)
                                 + (TOT_W'(1) << 25));
        end
        if (cmd.out_load) begin
            sample_reg <= y_ovf ? (yv[Y_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                : $signed(yv[23:0]);
        end
    end

    // rounding shift and saturation detect
    assign yv    = total_reg[TOT_W-1:26];
    assign y_top = yv[Y_W-1:23];
    assign y_ovf = !((&y_top) || !(|y_top));

    assign m_sample_out = sample_reg;

    // status
    assign n_plus         = {1'b0, n_reg} + 1'b1;
    assign stat.div_done  = div_done;
    assign stat.chorus_on = depth_reg != '0;
    assign stat.no_parts  = count_reg == '0;
    assign stat.last_part = n_plus == {1'b0, count_reg};

    // partial reads stay within the active count
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.part_rd |-> (n_reg < count_reg))
        else $error("partial read beyond active count");

    // valid bits change only on a load
    a_valid_by_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(cmd.load)) |-> $stable(valid_reg))
        else $error("valid bits changed without a load");

endmodule

`default_nettype wire

>>> sv/dpob_ctrl.sv
// ============================================================================
// dpob_ctrl
// Controller: sequences loads, the damping divide, the chorus gain, the
// per-partial loop, the final scaling and the output register handshake.
// ============================================================================
`default_nettype none

module dpob_ctrl (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_req_type,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dpob_pkg::stat_t stat,
    output dpob_pkg::cmd_t  cmd
);
    import dpob_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DIV    = 13'b0000000000010,
        S_CH_RD  = 13'b0000000000100,
        S_CH_MUL = 13'b0000000001000,
        S_CH_AM  = 13'b0000000010000,
        S_P_RD   = 13'b0000000100000,
        S_P_SINE = 13'b0000001000000,
        S_P_MUL1 = 13'b0000010000000,
        S_P_MUL2 = 13'b0000100000000,
        S_P_ACC  = 13'b0001000000000,
        S_F_MUL  = 13'b0010000000000,
        S_F_ADD  = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   in_xfer;
    logic   out_free;

    assign s_ready  = state_reg == S_IDLE;
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_req_type) begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_DIV;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    if (stat.chorus_on) begin
                        state_next = S_CH_RD;
                    end else if (stat.no_parts) begin
                        state_next = S_F_MUL;
                    end else begin
                        state_next = S_P_RD;
                    end
                end
            end
            S_CH_RD: begin
                cmd.ch_rd  = 1'b1;
                state_next = S_CH_MUL;
            end
            S_CH_MUL: begin
                cmd.ch_mul = 1'b1;
                state_next = S_CH_AM;
            end
            S_CH_AM: begin
                cmd.ch_am  = 1'b1;
                state_next = stat.no_parts ? S_F_MUL : S_P_RD;
            end
            S_P_RD: begin
                cmd.part_rd = 1'b1;
                state_next  = S_P_SINE;
            end
            S_P_SINE: begin
                cmd.part_sine = 1'b1;
                state_next    = S_P_MUL1;
            end
            S_P_MUL1: begin
                cmd.part_mul1 = 1'b1;
                state_next    = S_P_MUL2;
            end
            S_P_MUL2: begin
                cmd.part_mul2 = 1'b1;
                state_next    = S_P_ACC;
            end
            S_P_ACC: begin
                cmd.part_acc = 1'b1;
                state_next   = stat.last_part ? S_F_MUL : S_P_RD;
            end
            S_F_MUL: begin
                cmd.fin_mul = 1'b1;
                state_next  = S_F_ADD;
            end
            S_F_ADD: begin
                cmd.fin_add = 1'b1;
                state_next  = S_OUT;
            end
            // wait for the output register to free up
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a tick transfer closes the input until the sample is produced
    a_tick_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_req_type) |=> !s_ready)
        else $error("input open right after a tick transfer");

    // a load transfer leaves the input open
    a_load_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_req_type) |=> s_ready)
        else $error("input closed after a load transfer");

    // a sample loaded into the output register is presented
    a_out_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid && s_ready))
        else $error("loaded sample not presented");

endmodule

`default_nettype wire
